// ===== sv/mppt_pkg.sv =====
// ----------------------------------------------------------------------------
// mppt_pkg
// Shared types and reset constants for the perturb-and-observe charger.
// ----------------------------------------------------------------------------
package mppt_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CRITICAL_INPUT_MV      = 3'd0,
    CFG_NOMINAL_INPUT_MV       = 3'd1,
    CFG_BATTERY_LIMIT_MV       = 3'd2,
    CFG_BATTERY_NOT_FULL_MV    = 3'd3,
    CFG_FULL_CHARGE_CURRENT_MA = 3'd4,
    CFG_INPUT_CURRENT_LIMIT_MA = 3'd5,
    CFG_REGULATION_MARGIN_MA   = 3'd6
  } cfg_idx_e;

  localparam logic [15:0] CriticalInputMvRst     = 16'd6500;
  localparam logic [15:0] NominalInputMvRst      = 16'd8000;
  localparam logic [15:0] BatteryLimitMvRst      = 16'd4210;
  localparam logic [15:0] BatteryNotFullMvRst    = 16'd4100;
  localparam logic [15:0] FullChargeCurrentMaRst = 16'd160;
  localparam logic [15:0] InputCurrentLimitMaRst = 16'd700;
  localparam logic [7:0]  RegulationMarginMaRst  = 8'd5;

  localparam logic [15:0] ThresholdMax = 16'hFFFF;

  typedef struct packed {
    logic [15:0] input_mv;
    logic [15:0] input_ma;
    logic [15:0] battery_mv;
    logic [15:0] battery_ma;
    logic [31:0] power;
  } in_t;

  typedef struct packed {
    logic step_up;
    logic duty_step;
    logic battery_connected;
    logic pwm_start;
    logic pwm_stop;
    logic converter_enable;
    logic fully_charged;
  } out_t;

  typedef struct packed {
    logic [15:0] critical_input_mv;
    logic [15:0] nominal_input_mv;
    logic [15:0] battery_limit_mv;
    logic [15:0] battery_not_full_mv;
    logic [15:0] full_charge_current_ma;
    logic [15:0] input_current_limit_ma;
    logic [7:0]  regulation_margin_ma;
  } cfg_t;

  typedef struct packed {
    logic        awaiting_first;
    logic        battery_on;
    logic        charge_full;
    logic        direction_up;
    logic [15:0] current_threshold;
    logic [31:0] previous_power;
    logic        dcdc_on;
  } state_t;

  localparam state_t StateRst = '{
    awaiting_first:    1'b1,
    battery_on:        1'b0,
    charge_full:       1'b0,
    direction_up:      1'b1,
    current_threshold: 16'd0,
    previous_power:    32'd0,
    dcdc_on:           1'b1
  };

endpackage

// ===== sv/mppt_decide.sv =====
// ----------------------------------------------------------------------------
// mppt_decide
// Per-frame decision logic: battery toggling, full-charge hysteresis and
// perturb-and-observe direction, giving the next state and the result.
// ----------------------------------------------------------------------------
module mppt_decide (
  input  mppt_pkg::cfg_t   cfg_i,
  input  mppt_pkg::state_t state_i,
  input  mppt_pkg::in_t    frame_i,
  output mppt_pkg::state_t state_o,
  output mppt_pkg::out_t   result_o
);
  import mppt_pkg::*;

  logic [16:0] thr_sum;
  state_t      st;
  logic        start_pulse;
  logic        stop_pulse;
  logic        stepped;

  assign thr_sum = {1'b0, frame_i.input_ma} + {9'd0, cfg_i.regulation_margin_ma};

  always_comb begin
    st          = state_i;
    start_pulse = 1'b0;
    stop_pulse  = 1'b0;
    stepped     = 1'b0;

    // threshold is latched from the first frame only
    if (st.awaiting_first) begin
      st.current_threshold = thr_sum[16] ? ThresholdMax : thr_sum[15:0];
      st.awaiting_first    = 1'b0;
    end

    // low input toggles the switch from frame to frame
    if ((frame_i.input_mv < cfg_i.critical_input_mv) && st.battery_on) begin
      st.battery_on = 1'b0;
      start_pulse   = 1'b1;
    end else if (!st.battery_on) begin
      st.battery_on = 1'b1;
    end

    if (st.charge_full) begin
      if (frame_i.battery_mv < cfg_i.battery_not_full_mv) begin
        st.charge_full = 1'b0;
        start_pulse    = 1'b1;
        st.dcdc_on     = 1'b1;
      end
    end else if (st.battery_on) begin
      if ((frame_i.input_ma > cfg_i.input_current_limit_ma) ||
          (frame_i.input_mv < cfg_i.nominal_input_mv)) begin
        st.direction_up = 1'b0;
      end else if (frame_i.input_ma < st.current_threshold) begin
        st.direction_up = 1'b1;
      end else if (frame_i.battery_mv > cfg_i.battery_limit_mv) begin
        if (frame_i.battery_ma < cfg_i.full_charge_current_ma) begin
          st.charge_full = 1'b1;
          stop_pulse     = 1'b1;
          st.dcdc_on     = 1'b0;
        end
        st.direction_up = 1'b0;
      end else if (frame_i.power < st.previous_power) begin
        st.direction_up = !st.direction_up;
      end
      stepped           = 1'b1;
      st.previous_power = frame_i.power;
    end

    state_o                    = st;
    result_o.step_up           = st.direction_up;
    result_o.duty_step         = stepped;
    result_o.battery_connected = st.battery_on;
    result_o.pwm_start         = start_pulse;
    result_o.pwm_stop          = stop_pulse;
    result_o.converter_enable  = st.dcdc_on;
    result_o.fully_charged     = st.charge_full;
  end

endmodule

// ===== sv/mppt_perturb_observe_charger.sv =====
// a request accepted into the input register moves into the result register
// when the result register is free or its result is taken
// throughput: one request per cycle while results are taken; a held result
// stalls the input once the input register also holds a request
// reset: valid flags clear, limits and controller state return to defaults,
// cfg always ready
// ----------------------------------------------------------------------------
// mppt_perturb_observe_charger
// Perturb-and-observe MPPT charge controller, one ADC frame per request.
// ----------------------------------------------------------------------------
module mppt_perturb_observe_charger (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  mppt_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output mppt_pkg::out_t                 out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mppt_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [15:0]                    cfg_data_i
);
  import mppt_pkg::*;

  cfg_t   cfg_q;
  state_t state_q, state_d;
  in_t    frame_q;
  logic   frame_valid_q;
  out_t   result_q, result_d;
  logic   result_valid_q;
  logic   out_adv;
  logic   process;

  assign out_adv     = !result_valid_q || out_ready_i;
  assign process     = frame_valid_q && out_adv;
  assign in_ready_o  = !frame_valid_q || out_adv;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = result_valid_q;
  assign out_data_o  = result_q;

  mppt_decide u_decide (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .frame_i  (frame_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{
        critical_input_mv:      CriticalInputMvRst,
        nominal_input_mv:       NominalInputMvRst,
        battery_limit_mv:       BatteryLimitMvRst,
        battery_not_full_mv:    BatteryNotFullMvRst,
        full_charge_current_ma: FullChargeCurrentMaRst,
        input_current_limit_ma: InputCurrentLimitMaRst,
        regulation_margin_ma:   RegulationMarginMaRst
      };
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CRITICAL_INPUT_MV:      cfg_q.critical_input_mv      <= cfg_data_i;
        CFG_NOMINAL_INPUT_MV:       cfg_q.nominal_input_mv       <= cfg_data_i;
        CFG_BATTERY_LIMIT_MV:       cfg_q.battery_limit_mv       <= cfg_data_i;
        CFG_BATTERY_NOT_FULL_MV:    cfg_q.battery_not_full_mv    <= cfg_data_i;
        CFG_FULL_CHARGE_CURRENT_MA: cfg_q.full_charge_current_ma <= cfg_data_i;
        CFG_INPUT_CURRENT_LIMIT_MA: cfg_q.input_current_limit_ma <= cfg_data_i;
        CFG_REGULATION_MARGIN_MA:   cfg_q.regulation_margin_ma   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_valid_q  <= 1'b0;
      result_valid_q <= 1'b0;
      state_q        <= StateRst;
    end else begin
      if (in_ready_o) begin
        frame_valid_q <= in_valid_i;
      end
      if (out_adv) begin
        result_valid_q <= frame_valid_q;
      end
      if (process) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      frame_q <= in_data_i;
    end
    if (process) begin
      result_q <= result_d;
    end
  end

  // restart and stop never come from the same frame
  a_pulse_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.pwm_start && out_data_o.pwm_stop))
    else $error("pwm start and stop in one result");

  // converter is off exactly while fully charged
  a_dcdc_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.dcdc_on == !state_q.charge_full)
    else $error("converter enable out of step with full state");

  // a duty step needs the battery switched in
  a_step_batt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.duty_step |-> out_data_o.battery_connected)
    else $error("duty step with battery disconnected");

  // threshold is taken once, on the first processed frame
  a_first_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    process |=> !state_q.awaiting_first)
    else $error("still awaiting first frame after processing");

endmodule
